// ===== rtl/core/mefb_pkg.sv =====
// Shared types and constants for the motor encoder feedback tracker.
// No dependencies.
package mefb_pkg;

   localparam int MEFB_NUM_MOTORS = 4;

   localparam int ID_W    = 11;
   localparam int CALF_W  = 8;
   localparam int CSR_W   = 11;
   localparam int ANGLE_W = 16;
   localparam int TURNS_W = 32;

   localparam logic [ID_W-1:0]   BASE_ID_RESET  = 11'd513;
   localparam logic [CALF_W-1:0] CAL_FRAMES_RESET = 8'd50;

   // register indexes on the write port
   localparam logic CSR_BASE_ID    = 1'b0;
   localparam logic CSR_CAL_FRAMES = 1'b1;

   localparam logic signed [ANGLE_W:0] HALF_TURN = 17'sd4096;
   localparam int FULL_TURN_SHIFT = 13;

   typedef struct packed {
      logic [CALF_W-1:0]  frame_count;
      logic [ANGLE_W-1:0] prev_angle;
      logic [ANGLE_W-1:0] zero_angle;
      logic [TURNS_W-1:0] turns;
   } motor_state_type;

   typedef struct packed {
      logic               calibrating;
      logic [TURNS_W-1:0] unwrapped_angle;
   } update_status_type;

endpackage

// ===== rtl/core/motor_encoder_feedback_tracker_core.sv =====
// Motor feedback tracker: unpacks feedback frames and unwraps per-motor angle.
// Depends on mefb_pkg, mefb_state_mem and mefb_update.
//
// Answers frames addressed to motors base_id .. base_id+NUM_MOTORS-1 through
// stage 1 and the result register; other frames are dropped. The per-motor
// state sits in a small synchronous memory read in the cycle a frame is taken
// and written back as it leaves stage 1, with a bypass so that consecutive
// frames for the same motor see each other's update. The rate is one frame
// per clock unless rsp_ready stalls it, set by this read/write-back loop; the
// result register lets a new frame enter while a finished result waits.
module motor_encoder_feedback_tracker_core
   import mefb_pkg::*;
#(
   parameter int  NUM_MOTORS = MEFB_NUM_MOTORS,
   localparam int ADDR_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [CSR_W-1:0]    csr_wdata,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ID_W-1:0]     req_frame_id,
   input  logic [7:0]          req_byte0,
   input  logic [7:0]          req_byte1,
   input  logic [7:0]          req_byte2,
   input  logic [7:0]          req_byte3,
   input  logic [7:0]          req_byte4,
   input  logic [7:0]          req_byte5,
   input  logic [7:0]          req_byte6,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_motor_index,
   output logic                rsp_calibrating,
   output logic [15:0]         rsp_angle,
   output logic signed [15:0]  rsp_shaft_speed,
   output logic signed [15:0]  rsp_current,
   output logic [7:0]          rsp_temperature,
   output logic signed [31:0]  rsp_turn_count,
   output logic signed [31:0]  rsp_unwrapped_angle
);

   localparam logic [ID_W-1:0] MOTOR_SPAN = ID_W'(NUM_MOTORS);

   logic [ID_W-1:0]   base_id_ff;
   logic [CALF_W-1:0] cal_frames_ff;

   logic [ID_W:0] id_off;
   logic          hit;
   logic          req_accept;
   logic          s1_advance;

   logic              s1_valid_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [1:0]        s1_motor_ff;
   logic [15:0]       s1_angle_ff;
   logic [15:0]       s1_speed_ff;
   logic [15:0]       s1_current_ff;
   logic [7:0]        s1_temp_ff;

   motor_state_type   rd_state;
   motor_state_type   wr_state;
   update_status_type upd_status;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_motor_ff;
   logic              rsp_cal_ff;
   logic [15:0]       rsp_angle_ff;
   logic [15:0]       rsp_speed_ff;
   logic [15:0]       rsp_current_ff;
   logic [7:0]        rsp_temp_ff;
   logic [31:0]       rsp_turns_ff;
   logic [31:0]       rsp_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_id_ff    <= BASE_ID_RESET;
         cal_frames_ff <= CAL_FRAMES_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BASE_ID:    base_id_ff    <= csr_wdata[ID_W-1:0];
            CSR_CAL_FRAMES: cal_frames_ff <= csr_wdata[CALF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      id_off     = {1'b0, req_frame_id} - {1'b0, base_id_ff};
      hit        = !id_off[ID_W] && (id_off[ID_W-1:0] < MOTOR_SPAN);
      s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready  = !s1_valid_ff || s1_advance;
      req_accept = req_valid && req_ready;
   end

   mefb_state_mem #(
      .NUM_MOTORS (NUM_MOTORS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (id_off[ADDR_W-1:0]),
      .rd_data (rd_state),
      .wr_en   (s1_advance),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_state)
   );

   mefb_update u_update (
      .cur_state  (rd_state),
      .angle      (s1_angle_ff),
      .cal_frames (cal_frames_ff),
      .next_state (wr_state),
      .status     (upd_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= hit;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_addr_ff    <= id_off[ADDR_W-1:0];
         s1_motor_ff   <= id_off[1:0];
         s1_angle_ff   <= {req_byte0, req_byte1};
         s1_speed_ff   <= {req_byte2, req_byte3};
         s1_current_ff <= {req_byte4, req_byte5};
         s1_temp_ff    <= req_byte6;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_motor_ff   <= s1_motor_ff;
         rsp_cal_ff     <= upd_status.calibrating;
         rsp_angle_ff   <= s1_angle_ff;
         rsp_speed_ff   <= s1_speed_ff;
         rsp_current_ff <= s1_current_ff;
         rsp_temp_ff    <= s1_temp_ff;
         rsp_turns_ff   <= wr_state.turns;
         rsp_total_ff   <= upd_status.unwrapped_angle;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_motor_index     = rsp_motor_ff;
   assign rsp_calibrating     = rsp_cal_ff;
   assign rsp_angle           = rsp_angle_ff;
   assign rsp_shaft_speed     = $signed(rsp_speed_ff);
   assign rsp_current         = $signed(rsp_current_ff);
   assign rsp_temperature     = rsp_temp_ff;
   assign rsp_turn_count      = $signed(rsp_turns_ff);
   assign rsp_unwrapped_angle = $signed(rsp_total_ff);

   // a calibration item has total angle equal to turns times a full turn
   a_cal_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_cal_ff |-> rsp_total_ff == (rsp_turns_ff << FULL_TURN_SHIFT))
      else $error("calibration item total angle mismatch");

   a_drop_no_item: assert property (@(posedge clock) disable iff (reset)
      req_accept && !hit |=> !s1_valid_ff)
      else $error("dropped frame entered the pipeline");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_addr_ff))
      else $error("stalled item lost");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff && rsp_angle_ff == $past(s1_angle_ff))
      else $error("result register not loaded");

endmodule

// ===== rtl/core/mefb_state_mem.sv =====
// Per-motor state memory: synchronous read, one write port, valid bits and
// same-cycle write bypass. Depends on mefb_pkg.
module mefb_state_mem
   import mefb_pkg::*;
#(
   parameter int  NUM_MOTORS = MEFB_NUM_MOTORS,
   localparam int ADDR_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output motor_state_type rd_data,
   input  logic            wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  motor_state_type wr_data
);

   motor_state_type mem [NUM_MOTORS];
   logic [NUM_MOTORS-1:0] valid_ff;
   motor_state_type mem_rd_ff;
   logic            entry_valid_ff;
   logic            byp_ff;
   motor_state_type byp_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         entry_valid_ff <= 1'b0;
         byp_ff         <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            entry_valid_ff <= valid_ff[rd_addr];
            byp_ff         <= wr_en && (wr_addr == rd_addr);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         byp_data_ff <= wr_data;
      end
   end

   always_comb begin
      if (byp_ff) begin
         rd_data = byp_data_ff;
      end else if (entry_valid_ff) begin
         rd_data = mem_rd_ff;
      end else begin
         rd_data = '0;
      end
   end

endmodule

// ===== rtl/core/mefb_update.sv =====
// Calibration, turn unwrapping and total angle for one motor item.
// Depends on mefb_pkg.
module mefb_update
   import mefb_pkg::*;
(
   input  motor_state_type    cur_state,
   input  logic [ANGLE_W-1:0] angle,
   input  logic [CALF_W-1:0]  cal_frames,
   output motor_state_type    next_state,
   output update_status_type  status
);

   logic                      cal;
   logic signed [ANGLE_W:0]   diff;
   logic [TURNS_W-1:0]        turns_next;

   always_comb begin
      cal  = cur_state.frame_count <= cal_frames;
      diff = $signed({1'b0, angle}) - $signed({1'b0, cur_state.prev_angle});

      turns_next = cur_state.turns;
      if (!cal) begin
         if (diff > HALF_TURN) begin
            turns_next = cur_state.turns - 32'd1;
         end else if (diff < -HALF_TURN) begin
            turns_next = cur_state.turns + 32'd1;
         end
      end

      next_state.frame_count  = (cur_state.frame_count == 8'hFF) ?
                                cur_state.frame_count : cur_state.frame_count + 8'd1;
      next_state.prev_angle   = angle;
      next_state.zero_angle   = cal ? angle : cur_state.zero_angle;
      next_state.turns        = turns_next;

      status.calibrating     = cal;
      status.unwrapped_angle = (turns_next << FULL_TURN_SHIFT) + {16'd0, angle}
                               - {16'd0, next_state.zero_angle};
   end

endmodule
